[design/wdds_pkg.sv]
package wdds_pkg;

  // Phase word split: table index above, interpolation fraction below.
  localparam int TABLE_BITS = 10;
  localparam int PHASE_W    = 32;
  localparam int FRAC_W     = PHASE_W - TABLE_BITS;
  localparam int GAIN_W     = 16;
  localparam int SAMPLE_W   = 16;

  // Quarter-wave ROM: entries 0..QTR_N, magnitude only.
  localparam int QTR_N      = 1 << (TABLE_BITS - 2);
  localparam int ADDR_W     = TABLE_BITS - 1;
  localparam int MAG_W      = SAMPLE_W - 1;

  // Shift-add multiplier: 17-bit signed multiplicand, accumulator of ACC_W,
  // multiplier register of MPL_W bits (the full interpolated value).
  localparam int MCAND_W    = SAMPLE_W + 1;
  localparam int ACC_W      = MCAND_W + 1;
  localparam int MPL_W      = ACC_W + FRAC_W;
  localparam int CNT_W      = $clog2(MPL_W + 1);

  // Round and saturate: drop FRAC_W+15 bits of the product.
  localparam int RND_SH     = FRAC_W + SAMPLE_W - 1;
  localparam int KEEP_W     = MPL_W - RND_SH;
  localparam int Q_W        = ACC_W + KEEP_W + 1;

  localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] SAT_MIN = -Q_W'(32768);

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef logic [MAG_W-1:0] qtr_rom_t [QTR_N+1];

  typedef struct packed {
    logic             start;
    logic             sign_last;
    logic [CNT_W-1:0] steps;
  } wdds_mul_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_DIFF,
    ST_MUL1,
    ST_SUM,
    ST_MUL2,
    ST_OUT
  } wdds_state_t;

  // Q30 Taylor series of sin through x^17, rounded half up to Q15.
  function automatic logic [MAG_W-1:0] qtr_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x   = (64'(k) * TWO_PI_Q30 + (64'd1 << (TABLE_BITS - 1))) >> TABLE_BITS;
    x2  = (x * x) >> 30;
    t   = x;
    sum = $signed(x);
    t = ((t * x2) >> 30) / 64'd6;   sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd20;  sum = sum + $signed(t);
    t = ((t * x2) >> 30) / 64'd42;  sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd72;  sum = sum + $signed(t);
    t = ((t * x2) >> 30) / 64'd110; sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd156; sum = sum + $signed(t);
    t = ((t * x2) >> 30) / 64'd210; sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd272; sum = sum + $signed(t);
    if (sum < 0) begin
      sum = 0;
    end
    r = ($unsigned(sum) + (64'd1 << 14)) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[MAG_W-1:0];
  endfunction

  function automatic qtr_rom_t build_qtr();
    qtr_rom_t tbl;
    for (int k = 0; k <= QTR_N; k++) begin
      tbl[k] = qtr_entry(k);
    end
    return tbl;
  endfunction

  localparam qtr_rom_t SINE_QTR = build_qtr();

endpackage

[design/wdds_sermul.sv]
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module wdds_sermul
  import wdds_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  wdds_mul_ctl_t             ctl,
  input  logic signed [MCAND_W-1:0] mcand,
  input  logic [MPL_W-1:0]          mplier,
  output logic                      busy,
  output logic signed [ACC_W-1:0]   prod_hi,
  output logic [MPL_W-1:0]          prod_lo
);

  logic signed [ACC_W-1:0]   hi_r;
  logic [MPL_W-1:0]          lo_r;
  logic signed [MCAND_W-1:0] mc_r;
  logic                      sign_last_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [ACC_W:0]     addend;
  logic signed [ACC_W:0]     sum;

  // The sign bit of a signed multiplier weighs negative: subtract on it.
  always_comb begin
    addend = '0;
    if (lo_r[0]) begin
      if (sign_last_r && (cnt_r == CNT_W'(1))) begin
        addend = -(ACC_W+1)'(mc_r);
      end else begin
        addend = (ACC_W+1)'(mc_r);
      end
    end
    sum = {hi_r[ACC_W-1], hi_r} + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.start) begin
      cnt_r <= ctl.steps;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      hi_r        <= '0;
      lo_r        <= mplier;
      mc_r        <= mcand;
      sign_last_r <= ctl.sign_last;
    end else if (cnt_r != '0) begin
      hi_r <= sum[ACC_W:1];
      lo_r <= {sum[0], lo_r[MPL_W-1:1]};
    end
  end

  assign busy    = (cnt_r != '0);
  assign prod_hi = hi_r;
  assign prod_lo = lo_r;

endmodule

[design/wavetable_sine_oscillator.sv]
// Channel   Handshake                  Payload
// input     in_valid / in_ready        in_phase_offset[31:0] s, in_envelope_gain[15:0] u
// result    out_valid / out_ready      out_sample_out[15:0] s
// config    cfg_wr_en (no wait)        cfg_wr_data[31:0] -> phase step
//
// One transaction in gives one sample out. The time per sample, from
// accept to the next accept, is set by the bit-serial multiplier: one pass
// over the fraction bits for the interpolation, one over the interpolated
// value for the gain. A new transaction is taken only in the idle state.
// Synchronous active-low reset clears phase, phase step and the output
// valid flag. A finished sample waits in the output register while the
// next transaction is already taken in; only a full output register holds
// the engine in its final state.
module wavetable_sine_oscillator
  import wdds_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [PHASE_W-1:0]  in_phase_offset,
  input  logic [GAIN_W-1:0]          in_envelope_gain,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_wr_en,
  input  logic [PHASE_W-1:0]         cfg_wr_data
);

  wdds_state_t state_r, state_nxt;

  logic [PHASE_W-1:0]         phase_r;
  logic [PHASE_W-1:0]         step_r;
  logic [TABLE_BITS-1:0]      idx_r;
  logic [FRAC_W-1:0]          frac_r;
  logic [GAIN_W-1:0]          gain_r;
  logic signed [SAMPLE_W-1:0] a_r;
  logic [MAG_W-1:0]           rom_q_r;
  logic                       rom_neg_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  // Control strobes from the output decode.
  logic          take_in;
  logic          sel_next;
  logic          load_a;
  logic          load_out;
  wdds_mul_ctl_t mul_ctl;

  // ROM addressing with quarter-wave fold.
  logic [TABLE_BITS:0]   rom_j;
  logic [ADDR_W-1:0]     rom_k;
  logic [ADDR_W-1:0]     rom_addr;
  logic signed [SAMPLE_W-1:0] rom_val;

  // Datapath.
  logic signed [MCAND_W-1:0] mcand;
  logic [MPL_W-1:0]          mplier;
  logic                      mul_busy;
  logic signed [ACC_W-1:0]   mul_hi;
  logic [MPL_W-1:0]          mul_lo;
  logic signed [ACC_W-1:0]   s_hi;
  logic signed [Q_W-1:0]     q_rnd;
  logic signed [SAMPLE_W-1:0] q_sat;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RD_A;
        end
      end
      ST_RD_A: state_nxt = ST_RD_B;
      ST_RD_B: state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_MUL1;
      ST_MUL1: begin
        if (!mul_busy) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM:  state_nxt = ST_MUL2;
      ST_MUL2: begin
        if (!mul_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Output decode
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready          = 1'b0;
    sel_next          = 1'b0;
    load_a            = 1'b0;
    load_out          = 1'b0;
    mul_ctl.start     = 1'b0;
    mul_ctl.sign_last = 1'b0;
    mul_ctl.steps     = CNT_W'(FRAC_W);
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_RD_B: begin
        // read next entry, capture the first
        sel_next = 1'b1;
        load_a   = 1'b1;
      end
      ST_DIFF: begin
        // (b - a) * frac, fraction is unsigned
        mul_ctl.start = 1'b1;
        mul_ctl.steps = CNT_W'(FRAC_W);
      end
      ST_SUM: begin
        // s * gain, s is signed: subtract on its sign bit
        mul_ctl.start     = 1'b1;
        mul_ctl.sign_last = 1'b1;
        mul_ctl.steps     = CNT_W'(MPL_W);
      end
      ST_OUT: load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign take_in = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Sine ROM: quarter wave, sign from the half-period bit. The index one
  // past the end folds to entry zero, which is the required zero entry.
  // ---------------------------------------------------------------------
  assign rom_j = sel_next ? ({1'b0, idx_r} + (TABLE_BITS+1)'(1)) : {1'b0, idx_r};
  assign rom_k = rom_j[ADDR_W-1:0];

  always_comb begin
    if (rom_k > ADDR_W'(QTR_N)) begin
      rom_addr = ~rom_k + ADDR_W'(1);   // half - k
    end else begin
      rom_addr = rom_k;
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r   <= SINE_QTR[rom_addr];
    rom_neg_r <= rom_j[TABLE_BITS-1];
  end

  assign rom_val = rom_neg_r ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});

  // ---------------------------------------------------------------------
  // Multiplier operands
  // ---------------------------------------------------------------------
  // s = a * 2^F + (b - a) * frac: add a to the top of the first product.
  assign s_hi = mul_hi + ACC_W'(a_r);

  always_comb begin
    if (state_r == ST_SUM) begin
      mcand  = $signed({1'b0, gain_r});
      mplier = {s_hi, mul_lo[MPL_W-1 -: FRAC_W]};
    end else begin
      mcand  = MCAND_W'(rom_val) - MCAND_W'(a_r);
      mplier = MPL_W'(frac_r);
    end
  end

  wdds_sermul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mul_ctl),
    .mcand   (mcand),
    .mplier  (mplier),
    .busy    (mul_busy),
    .prod_hi (mul_hi),
    .prod_lo (mul_lo)
  );

  // ---------------------------------------------------------------------
  // Round half up and saturate: floor(v / 2^RND_SH) plus the bit below.
  // ---------------------------------------------------------------------
  assign q_rnd = Q_W'($signed({mul_hi, mul_lo[MPL_W-1:RND_SH]}))
               + Q_W'({1'b0, mul_lo[RND_SH-1]});

  always_comb begin
    if (q_rnd > SAT_MAX) begin
      q_sat = SAMPLE_W'(SAT_MAX);
    end else if (q_rnd < SAT_MIN) begin
      q_sat = SAMPLE_W'(SAT_MIN);
    end else begin
      q_sat = q_rnd[SAMPLE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
      // advance the phase as soon as this sample's index and fraction are taken
      if (take_in) begin
        phase_r <= phase_r + step_r + $unsigned(in_phase_offset);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (take_in) begin
      idx_r  <= phase_r[PHASE_W-1 -: TABLE_BITS];
      frac_r <= phase_r[FRAC_W-1:0];
      gain_r <= in_envelope_gain;
    end
    if (load_a) begin
      a_r <= rom_val;
    end
    if (load_out) begin
      out_sample_r <= q_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule
